FILE: src/hskrt_pkg.sv
// shared types and constants for the six-key report tracker
package hskrt_pkg;

   typedef enum logic [1:0] {
      OP_PRESS       = 2'd0,
      OP_RELEASE     = 2'd1,
      OP_RELEASE_ALL = 2'd2,
      OP_UNUSED      = 2'd3
   } op_type;

   localparam int unsigned REPORT_KEYS = 6;
   localparam logic [4:0] MOD_CODE_HIGH = 5'b11100;
   localparam logic [7:0] SHIFT_MASK = 8'h22;
   localparam logic [7:0] EMPTY_SLOT = 8'h00;

   typedef struct packed {
      logic       valid;
      op_type     operation;
      logic [7:0] key_code;
      logic       mask_shift;
   } req_type;

   typedef struct packed {
      logic                             valid;
      logic [7:0]                       modifiers;
      logic [REPORT_KEYS-1:0][7:0]      keys;
   } rsp_type;

endpackage

FILE: src/hskrt_req_reg.sv
// input register for accepted transactions
module hskrt_req_reg (
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  logic [1:0]          operation,
   input  logic [7:0]          key_code,
   input  logic                mask_shift,
   output hskrt_pkg::req_type  req
);
   import hskrt_pkg::*;

   logic       valid_ff, valid_in;
   op_type     op_ff;
   logic [7:0] code_ff;
   logic       supp_ff;

   assign valid_in = accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff   <= op_type'(operation);
         code_ff <= key_code;
         supp_ff <= mask_shift;
      end
   end

   always_comb begin
      req.valid      = valid_ff;
      req.operation  = op_ff;
      req.key_code   = code_ff;
      req.mask_shift = supp_ff;
   end

endmodule

FILE: src/hskrt_core.sv
// report state registers and single-pass update logic
module hskrt_core #(
   parameter int unsigned KEY_SLOTS = 6
) (
   input  logic                clock,
   input  logic                reset,
   input  hskrt_pkg::req_type  req,
   output hskrt_pkg::rsp_type  rsp_next
);
   import hskrt_pkg::*;

   logic [7:0] mods_ff, mods_in;
   logic [7:0] slots_ff [KEY_SLOTS];
   logic [7:0] slots_in [KEY_SLOTS];

   logic [KEY_SLOTS-1:0] match_vec, free_vec, match_first, free_first;
   logic                 is_mod, changed;
   logic [7:0]           mod_bit;
   logic [REPORT_KEYS-1:0][7:0] keys_w;

   always_comb begin
      for (int i = 0; i < KEY_SLOTS; i++) begin
         match_vec[i] = (slots_ff[i] == req.key_code);
         free_vec[i]  = (slots_ff[i] == EMPTY_SLOT);
      end
   end

   assign match_first = match_vec & (~match_vec + KEY_SLOTS'(1));
   assign free_first  = free_vec & (~free_vec + KEY_SLOTS'(1));
   assign is_mod      = (req.key_code[7:3] == MOD_CODE_HIGH);
   assign mod_bit     = 8'h01 << req.key_code[2:0];

   always_comb begin
      mods_in = mods_ff;
      for (int i = 0; i < KEY_SLOTS; i++) begin
         slots_in[i] = slots_ff[i];
      end
      changed = 1'b0;
      if (req.valid) begin
         unique case (req.operation)
            OP_RELEASE_ALL: begin
               changed = 1'b1;
               mods_in = 8'h00;
               for (int i = 0; i < KEY_SLOTS; i++) begin
                  slots_in[i] = EMPTY_SLOT;
               end
            end
            OP_PRESS: begin
               if (req.key_code != EMPTY_SLOT) begin
                  if (is_mod) begin
                     changed = ((mods_ff & mod_bit) == 8'h00);
                     mods_in = mods_ff | mod_bit;
                  end else if (!(|match_vec) && (|free_vec)) begin
                     changed = 1'b1;
                     for (int i = 0; i < KEY_SLOTS; i++) begin
                        if (free_first[i]) begin
                           slots_in[i] = req.key_code;
                        end
                     end
                  end
               end
            end
            OP_RELEASE: begin
               if (req.key_code != EMPTY_SLOT) begin
                  if (is_mod) begin
                     changed = ((mods_ff & mod_bit) != 8'h00);
                     mods_in = mods_ff & ~mod_bit;
                  end else if (|match_vec) begin
                     changed = 1'b1;
                     for (int i = 0; i < KEY_SLOTS; i++) begin
                        if (match_first[i]) begin
                           slots_in[i] = EMPTY_SLOT;
                        end
                     end
                  end
               end
            end
            default: begin
               changed = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mods_ff <= 8'h00;
         for (int i = 0; i < KEY_SLOTS; i++) begin
            slots_ff[i] <= EMPTY_SLOT;
         end
      end else begin
         mods_ff <= mods_in;
         for (int i = 0; i < KEY_SLOTS; i++) begin
            slots_ff[i] <= slots_in[i];
         end
      end
   end

   for (genvar j = 0; j < REPORT_KEYS; j++) begin : g_keys
      if (j < KEY_SLOTS) begin : g_slot
         assign keys_w[j] = slots_in[j];
      end else begin : g_none
         assign keys_w[j] = EMPTY_SLOT;
      end
   end

   always_comb begin
      rsp_next.valid     = changed;
      rsp_next.modifiers = req.mask_shift ? (mods_in & ~SHIFT_MASK) : mods_in;
      rsp_next.keys      = keys_w;
   end

endmodule

FILE: src/hskrt_rsp_reg.sv
// result register driving the strobed report
module hskrt_rsp_reg (
   input  logic                clock,
   input  logic                reset,
   input  hskrt_pkg::rsp_type  rsp_next,
   output hskrt_pkg::rsp_type  rsp
);
   import hskrt_pkg::*;

   logic                        valid_ff, valid_in;
   logic [7:0]                  mods_ff;
   logic [REPORT_KEYS-1:0][7:0] keys_ff;

   assign valid_in = rsp_next.valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (valid_in) begin
         mods_ff <= rsp_next.modifiers;
         keys_ff <= rsp_next.keys;
      end
   end

   always_comb begin
      rsp.valid     = valid_ff;
      rsp.modifiers = mods_ff;
      rsp.keys      = keys_ff;
   end

endmodule

FILE: src/hid_six_key_report_tracker_unit.sv
// top level of the six-key boot keyboard report tracker
// each report is registered in the input register and then in the result register
// throughput: one transaction per cycle; busy stays low, the state updates each cycle
// the receiver cannot stall: each report is on the rsp_ ports for exactly one cycle
// reset (synchronous, active high) clears the modifiers, all key slots and both valid stages
module hid_six_key_report_tracker_unit #(
   parameter int unsigned KEY_SLOTS = 6
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  logic [1:0] req_operation,
   input  logic [7:0] req_key_code,
   input  logic       req_mask_shift,
   output logic       rsp_strobe,
   output logic [7:0] rsp_report_modifiers,
   output logic [7:0] rsp_report_key0,
   output logic [7:0] rsp_report_key1,
   output logic [7:0] rsp_report_key2,
   output logic [7:0] rsp_report_key3,
   output logic [7:0] rsp_report_key4,
   output logic [7:0] rsp_report_key5
);
   import hskrt_pkg::*;

   req_type req;
   rsp_type rsp_next, rsp;
   logic    accept;

   assign busy   = 1'b0;
   assign accept = start & ~busy;

   hskrt_req_reg u_req_reg (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .operation  (req_operation),
      .key_code   (req_key_code),
      .mask_shift (req_mask_shift),
      .req        (req)
   );

   hskrt_core #(
      .KEY_SLOTS (KEY_SLOTS)
   ) u_core (
      .clock    (clock),
      .reset    (reset),
      .req      (req),
      .rsp_next (rsp_next)
   );

   hskrt_rsp_reg u_rsp_reg (
      .clock    (clock),
      .reset    (reset),
      .rsp_next (rsp_next),
      .rsp      (rsp)
   );

   assign rsp_strobe           = rsp.valid;
   assign rsp_report_modifiers = rsp.modifiers;
   assign rsp_report_key0      = rsp.keys[0];
   assign rsp_report_key1      = rsp.keys[1];
   assign rsp_report_key2      = rsp.keys[2];
   assign rsp_report_key3      = rsp.keys[3];
   assign rsp_report_key4      = rsp.keys[4];
   assign rsp_report_key5      = rsp.keys[5];

endmodule

FILE: src/hskrt_checker.sv
// port-level checker for the report tracker and its bind
module hskrt_checker (
   input logic       clock,
   input logic       reset,
   input logic       start,
   input logic       busy,
   input logic [1:0] req_operation,
   input logic [7:0] req_key_code,
   input logic       req_mask_shift,
   input logic       rsp_strobe,
   input logic [7:0] rsp_report_modifiers,
   input logic [7:0] rsp_report_key0,
   input logic [7:0] rsp_report_key1,
   input logic [7:0] rsp_report_key2,
   input logic [7:0] rsp_report_key3,
   input logic [7:0] rsp_report_key4,
   input logic [7:0] rsp_report_key5
);
   import hskrt_pkg::*;

   logic accept;
   assign accept = start & ~busy;

   // every report traces back to an accepted transaction through the input and result registers
   a_strobe_source: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(accept, 2))
      else $error("report without an accepted transaction");

   // release all always gives an all-zero report
   a_release_all: assert property (@(posedge clock) disable iff (reset)
      accept && req_operation == OP_RELEASE_ALL |=> ##1
         rsp_strobe && rsp_report_modifiers == 8'h00 &&
         rsp_report_key0 == 8'h00 && rsp_report_key1 == 8'h00 &&
         rsp_report_key2 == 8'h00 && rsp_report_key3 == 8'h00 &&
         rsp_report_key4 == 8'h00 && rsp_report_key5 == 8'h00)
      else $error("release all did not give an empty report");

   // unused operation and null key code (other than release all) never report
   a_no_report: assert property (@(posedge clock) disable iff (reset)
      accept && (req_operation == OP_UNUSED ||
                 (req_operation != OP_RELEASE_ALL && req_key_code == 8'h00))
         |=> ##1 !rsp_strobe)
      else $error("report for a transaction that changes nothing");

   // masked shift bits stay clear in the report
   a_shift_masked: assert property (@(posedge clock) disable iff (reset)
      accept && req_mask_shift |=> ##1
         (!rsp_strobe || (rsp_report_modifiers & SHIFT_MASK) == 8'h00))
      else $error("shift bits present while masked");

endmodule

bind hid_six_key_report_tracker_unit hskrt_checker u_hskrt_checker (
   .clock                (clock),
   .reset                (reset),
   .start                (start),
   .busy                 (busy),
   .req_operation        (req_operation),
   .req_key_code         (req_key_code),
   .req_mask_shift       (req_mask_shift),
   .rsp_strobe           (rsp_strobe),
   .rsp_report_modifiers (rsp_report_modifiers),
   .rsp_report_key0      (rsp_report_key0),
   .rsp_report_key1      (rsp_report_key1),
   .rsp_report_key2      (rsp_report_key2),
   .rsp_report_key3      (rsp_report_key3),
   .rsp_report_key4      (rsp_report_key4),
   .rsp_report_key5      (rsp_report_key5)
);

FILE: sim/hid_six_key_report_tracker_unit_test.sv
// self-checking testbench for the six-key boot keyboard report tracker
`timescale 1ns / 1ps

module hid_six_key_report_tracker_unit_test;
   import hskrt_pkg::*;

   localparam logic [7:0] MOD_FIRST  = 8'hE0;
   localparam logic [7:0] MOD_LAST   = 8'hE7;
   localparam logic [7:0] SHIFT_BITS = 8'h22;
   localparam logic [7:0] NULL_CODE  = 8'h00;

   typedef struct packed {
      logic [7:0]                  mods;
      logic [REPORT_KEYS-1:0][7:0] keys;
   } key_report_type;

   logic       clock;
   logic       reset;
   logic       start;
   logic       busy;
   logic [1:0] req_operation;
   logic [7:0] req_key_code;
   logic       req_mask_shift;
   logic       rsp_strobe;
   logic [7:0] rsp_report_modifiers;
   logic [7:0] rsp_report_key0;
   logic [7:0] rsp_report_key1;
   logic [7:0] rsp_report_key2;
   logic [7:0] rsp_report_key3;
   logic [7:0] rsp_report_key4;
   logic [7:0] rsp_report_key5;

   logic [7:0]                  held_mods;
   logic [REPORT_KEYS-1:0][7:0] held_keys;
   key_report_type              pending_reports[$];
   key_report_type              got_report;
   key_report_type              want_report;

   int  mismatch_count;
   int  reports_checked;
   int  press_count;
   int  release_count;
   int  release_all_count;
   int  ignored_count;
   bit  steady_run;

   hid_six_key_report_tracker_unit u_top (
      .clock                (clock),
      .reset                (reset),
      .start                (start),
      .busy                 (busy),
      .req_operation        (req_operation),
      .req_key_code         (req_key_code),
      .req_mask_shift       (req_mask_shift),
      .rsp_strobe           (rsp_strobe),
      .rsp_report_modifiers (rsp_report_modifiers),
      .rsp_report_key0      (rsp_report_key0),
      .rsp_report_key1      (rsp_report_key1),
      .rsp_report_key2      (rsp_report_key2),
      .rsp_report_key3      (rsp_report_key3),
      .rsp_report_key4      (rsp_report_key4),
      .rsp_report_key5      (rsp_report_key5)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("hid_six_key_report_tracker_unit verification failed");
      $finish;
   end

   function automatic bit apply_key_event(input op_type op, input logic [7:0] code,
                                          input logic sup, output key_report_type rpt);
      logic [7:0] bit_sel;
      int         free_slot;
      bit         changed;
      changed   = 1'b0;
      free_slot = -1;
      bit_sel   = 8'h01 << code[2:0];
      rpt       = '0;
      if (op == OP_RELEASE_ALL) begin
         held_mods = '0;
         held_keys = '0;
         return 1'b1;
      end
      if (op == OP_UNUSED || code == NULL_CODE) begin
         return 1'b0;
      end
      if (code >= MOD_FIRST && code <= MOD_LAST) begin
         if (op == OP_PRESS) begin
            changed   = (held_mods & bit_sel) == 8'h00;
            held_mods = held_mods | bit_sel;
         end else begin
            changed   = (held_mods & bit_sel) != 8'h00;
            held_mods = held_mods & ~bit_sel;
         end
      end else if (op == OP_PRESS) begin
         changed = 1'b1;
         for (int i = 0; i < REPORT_KEYS; i++) begin
            if (held_keys[i] == code) changed = 1'b0;
            if (held_keys[i] == NULL_CODE && free_slot < 0) free_slot = i;
         end
         if (free_slot < 0) changed = 1'b0;
         if (changed) held_keys[free_slot] = code;
      end else begin
         for (int i = 0; i < REPORT_KEYS; i++) begin
            if (!changed && held_keys[i] == code) begin
               held_keys[i] = NULL_CODE;
               changed      = 1'b1;
            end
         end
      end
      rpt.mods = sup ? (held_mods & ~SHIFT_BITS) : held_mods;
      rpt.keys = held_keys;
      return changed;
   endfunction

   task automatic note_mismatch(input string field, input logic [7:0] want_v,
                                input logic [7:0] got_v);
      mismatch_count++;
      if (mismatch_count <= 10) begin
         $display("%0t: mismatch on %s: expected 0x%02h, got 0x%02h",
                  $realtime, field, want_v, got_v);
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         got_report.mods = rsp_report_modifiers;
         got_report.keys = {rsp_report_key5, rsp_report_key4, rsp_report_key3,
                            rsp_report_key2, rsp_report_key1, rsp_report_key0};
         if (pending_reports.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
               $display("%0t: report with nothing expected, modifiers 0x%02h",
                        $realtime, got_report.mods);
            end
         end else begin
            want_report = pending_reports.pop_front();
            reports_checked++;
            if (want_report.mods !== got_report.mods) begin
               note_mismatch("report_modifiers", want_report.mods, got_report.mods);
            end
            for (int i = 0; i < REPORT_KEYS; i++) begin
               if (want_report.keys[i] !== got_report.keys[i]) begin
                  note_mismatch($sformatf("report_key%0d", i),
                                want_report.keys[i], got_report.keys[i]);
               end
            end
         end
      end
   end

   task automatic send_key_event(input op_type op, input logic [7:0] code,
                                 input logic sup);
      key_report_type rpt;
      while (!steady_run && $urandom_range(0, 99) < 22) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start          <= 1'b1;
      req_operation  <= op;
      req_key_code   <= code;
      req_mask_shift <= sup;
      do @(posedge clock); while (busy);
      if (apply_key_event(op, code, sup, rpt)) pending_reports.push_back(rpt);
      case (op)
         OP_PRESS:       press_count++;
         OP_RELEASE:     release_count++;
         OP_RELEASE_ALL: release_all_count++;
         default:        ignored_count++;
      endcase
   endtask

   task automatic test_modifier_keys();
      send_key_event(OP_PRESS, 8'hE0, 1'b0);
      send_key_event(OP_PRESS, 8'hE1, 1'b1);
      send_key_event(OP_PRESS, 8'hE5, 1'b1);
      send_key_event(OP_PRESS, 8'hE7, 1'b0);
      send_key_event(OP_PRESS, 8'hE7, 1'b0);
      send_key_event(OP_RELEASE, 8'hE1, 1'b1);
      send_key_event(OP_RELEASE, 8'hE1, 1'b0);
   endtask

   task automatic test_key_slots();
      send_key_event(OP_PRESS, 8'h01, 1'b0);
      send_key_event(OP_PRESS, 8'hFF, 1'b1);
      send_key_event(OP_PRESS, 8'hDF, 1'b0);
      send_key_event(OP_PRESS, 8'hE8, 1'b1);
      send_key_event(OP_PRESS, 8'h04, 1'b0);
      send_key_event(OP_PRESS, 8'h05, 1'b0);
      send_key_event(OP_PRESS, 8'h06, 1'b0);
      send_key_event(OP_PRESS, 8'hFF, 1'b0);
      send_key_event(OP_RELEASE, 8'hDF, 1'b1);
      send_key_event(OP_PRESS, 8'h06, 1'b0);
      send_key_event(OP_RELEASE, 8'h77, 1'b0);
      send_key_event(OP_PRESS, NULL_CODE, 1'b0);
      send_key_event(OP_RELEASE, NULL_CODE, 1'b1);
   endtask

   task automatic test_release_all();
      send_key_event(OP_UNUSED, 8'h04, 1'b1);
      send_key_event(OP_RELEASE_ALL, 8'hE5, 1'b1);
      send_key_event(OP_RELEASE_ALL, NULL_CODE, 1'b0);
   endtask

   task automatic test_random_typing();
      int         counted;
      int         roll;
      op_type     op;
      logic [7:0] code;
      counted = 0;
      while (counted < 800) begin
         steady_run = (counted >= 300 && counted < 450);
         roll = $urandom_range(0, 99);
         if (roll < 50)      op = OP_PRESS;
         else if (roll < 90) op = OP_RELEASE;
         else if (roll < 95) op = OP_RELEASE_ALL;
         else                op = OP_UNUSED;
         roll = $urandom_range(0, 99);
         if (roll < 30)      code = MOD_FIRST | 8'($urandom_range(0, 7));
         else if (roll < 85) code = 8'h04 + 8'($urandom_range(0, 9));
         else if (roll < 88) code = NULL_CODE;
         else                code = 8'($urandom_range(0, 255));
         send_key_event(op, code, 1'($urandom_range(0, 1)));
         counted++;
      end
      steady_run = 1'b0;
   endtask

   initial begin
      int waited;
      mismatch_count     = 0;
      reports_checked    = 0;
      press_count        = 0;
      release_count      = 0;
      release_all_count  = 0;
      ignored_count      = 0;
      steady_run         = 1'b0;
      held_mods          = '0;
      held_keys          = '0;
      reset              <= 1'b1;
      start              <= 1'b0;
      req_operation      <= OP_PRESS;
      req_key_code       <= NULL_CODE;
      req_mask_shift     <= 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_modifier_keys();
      test_key_slots();
      test_release_all();
      test_random_typing();

      start <= 1'b0;
      waited = 0;
      while (pending_reports.size() != 0 && waited < 100) begin
         @(posedge clock);
         waited++;
      end
      repeat (4) @(posedge clock);
      if (pending_reports.size() != 0) begin
         mismatch_count++;
         $display("%0d expected reports never arrived", pending_reports.size());
      end

      $display("sent %0d presses, %0d releases, %0d release-alls, %0d unused ops",
               press_count, release_count, release_all_count, ignored_count);
      $display("checked %0d reports, %0d mismatches", reports_checked, mismatch_count);
      if (mismatch_count == 0) begin
         $display("hid_six_key_report_tracker_unit verification clean");
      end else begin
         $display("hid_six_key_report_tracker_unit verification failed");
      end
      $finish;
   end

endmodule
